// ===== hdl/kwmm_pkg.sv =====
`timescale 1ns / 1ps
package kwmm_pkg;

    // Fixed field widths of the channels
    localparam int SRC_BITS       = 3;
    localparam int OUT_VALUE_BITS = 32;
    localparam int CFG_BITS       = 4;

    // Active source count after reset
    localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd8;

    // Control sequencer states
    typedef enum logic {
        S_IDLE,
        S_DECIDE
    } t_state;

    // Command broadcast to every cell of the sorted chain
    typedef struct packed {
        logic clr;  // empty the chain
        logic ins;  // insert the broadcast key in order
        logic pop;  // drop the head, shift the rest towards cell 0
    } t_cell_ctl;

endpackage

// ===== hdl/kwmm_in_if.sv =====
`timescale 1ns / 1ps
interface kwmm_in_if;
    import kwmm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [SRC_BITS-1:0]        source;
    logic signed [OUT_VALUE_BITS-1:0] value;
    logic                       exhausted;

    modport source_mp (output valid, input ready, output source, value, exhausted);
    modport sink (input valid, output ready, input source, value, exhausted);
endinterface

// ===== hdl/kwmm_out_if.sv =====
`timescale 1ns / 1ps
interface kwmm_out_if;
    import kwmm_pkg::*;

    logic                             valid;
    logic                             ready;
    logic signed [OUT_VALUE_BITS-1:0] min_value;
    logic [SRC_BITS-1:0]              from_source;
    logic                             finished;

    modport source (output valid, input ready, output min_value, from_source, finished);
    modport sink (input valid, output ready, input min_value, from_source, finished);
endinterface

// ===== hdl/kwmm_cfg_if.sv =====
`timescale 1ns / 1ps
interface kwmm_cfg_if;
    import kwmm_pkg::*;

    logic                valid;
    logic                ready;
    logic [CFG_BITS-1:0] data;

    modport source (output valid, input ready, output data);
    modport sink (input valid, output ready, input data);
endinterface

// ===== hdl/kwmm_cell.sv =====
`timescale 1ns / 1ps
// One cell of the sorted chain: holds one key, ascending from cell 0
module kwmm_cell #(
    parameter int KEY_BITS = 35
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  kwmm_pkg::t_cell_ctl      i_ctl,
    input  logic [KEY_BITS-1:0]      i_new_key,
    input  logic [KEY_BITS-1:0]      i_prev_key,
    input  logic                     i_prev_valid,
    input  logic                     i_prev_lt,
    input  logic [KEY_BITS-1:0]      i_next_key,
    input  logic                     i_next_valid,
    output logic [KEY_BITS-1:0]      o_key,
    output logic                     o_valid,
    output logic                     o_lt
);
    import kwmm_pkg::*;

    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] n_key;
    logic                r_valid;
    logic                n_valid;

    // New key belongs at or before this cell; empty cells count as +inf
    assign o_lt = !r_valid || (i_new_key < r_key);

    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        if (i_ctl.clr) begin
            n_valid = 1'b0;
        end else if (i_ctl.ins) begin
            if (o_lt) begin
                if (i_prev_lt) begin
                    // shift right: take the left neighbour's old content
                    n_key   = i_prev_key;
                    n_valid = i_prev_valid;
                end else begin
                    n_key   = i_new_key;
                    n_valid = 1'b1;
                end
            end
        end else if (i_ctl.pop) begin
            n_key   = i_next_key;
            n_valid = i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_key <= n_key;
    end

    assign o_key   = r_key;
    assign o_valid = r_valid;

endmodule

// ===== hdl/kwmm_chain.sv =====
`timescale 1ns / 1ps
// Row of cells kept in ascending key order; cell 0 holds the minimum
module kwmm_chain #(
    parameter int NUM_CELLS = 8,
    parameter int KEY_BITS  = 35
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kwmm_pkg::t_cell_ctl i_ctl,
    input  logic [KEY_BITS-1:0] i_new_key,
    output logic [KEY_BITS-1:0] o_head_key,
    output logic                o_head_valid
);
    import kwmm_pkg::*;

    logic [KEY_BITS-1:0] w_key   [NUM_CELLS];
    logic                w_valid [NUM_CELLS];
    logic                w_lt    [NUM_CELLS];

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        logic [KEY_BITS-1:0] w_pk;
        logic                w_pv;
        logic                w_pl;
        logic [KEY_BITS-1:0] w_nk;
        logic                w_nv;

        // left neighbour; cell 0 has none
        if (g == 0) begin : g_first
            assign w_pk = '0;
            assign w_pv = 1'b0;
            assign w_pl = 1'b0;
        end else begin : g_mid
            assign w_pk = w_key[g-1];
            assign w_pv = w_valid[g-1];
            assign w_pl = w_lt[g-1];
        end

        // right neighbour; the last cell refills empty on a pop
        if (g == NUM_CELLS - 1) begin : g_last
            assign w_nk = '0;
            assign w_nv = 1'b0;
        end else begin : g_inner
            assign w_nk = w_key[g+1];
            assign w_nv = w_valid[g+1];
        end

        kwmm_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_new_key    (i_new_key),
            .i_prev_key   (w_pk),
            .i_prev_valid (w_pv),
            .i_prev_lt    (w_pl),
            .i_next_key   (w_nk),
            .i_next_valid (w_nv),
            .o_key        (w_key[g]),
            .o_valid      (w_valid[g]),
            .o_lt         (w_lt[g])
        );
    end

    assign o_head_key   = w_key[0];
    assign o_head_valid = w_valid[0];

endmodule

// ===== hdl/k_way_min_merge_top.sv =====
`timescale 1ns / 1ps
// A transaction is taken in S_IDLE and decided in S_DECIDE; a result that it releases
//   is registered in the output register.
// No new input transaction is taken until the accept/decide sequencer is back in S_IDLE;
//   it waits in S_DECIDE while a result is due and the output register is stalled.
// Reset (synchronous, active low): active count 8, active slots pending, others done,
//   sorted chain empty, output register empty.
module k_way_min_merge_top #(
    parameter int NUM_SOURCES = 8,
    parameter int VALUE_BITS  = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kwmm_in_if.sink       i_in,
    kwmm_out_if.source    o_out,
    kwmm_cfg_if.sink      i_cfg
);
    import kwmm_pkg::*;

    localparam int IDX_BITS = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int KEY_BITS = VALUE_BITS + SRC_BITS;
    localparam logic [VALUE_BITS-1:0] SIGN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    t_state                      r_state, n_state;
    logic [CFG_BITS-1:0]         r_active, n_active;
    logic [NUM_SOURCES-1:0]      r_pend, n_pend;
    logic                        r_out_valid, n_out_valid;
    logic [OUT_VALUE_BITS-1:0]   r_min_value, n_min_value;
    logic [SRC_BITS-1:0]         r_from_source, n_from_source;
    logic                        r_finished, n_finished;

    t_cell_ctl                   w_ctl;
    logic [KEY_BITS-1:0]         w_new_key;
    logic [KEY_BITS-1:0]         w_head_key;
    logic                        w_head_valid;
    logic [IDX_BITS-1:0]         w_in_idx;
    logic [IDX_BITS-1:0]         w_head_idx;
    logic                        w_in_ok;
    logic                        w_in_acc;
    logic                        w_cfg_acc;
    logic                        w_out_free;

    // Pending mask for a fresh merge: sources below the clamped count
    function automatic logic [NUM_SOURCES-1:0] f_restart_mask(input logic [CFG_BITS-1:0] cnt);
        logic [NUM_SOURCES-1:0] m;
        int                     eff;
        eff = int'(cnt);
        if (eff < 1) begin
            eff = 1;
        end
        if (eff > NUM_SOURCES) begin
            eff = NUM_SOURCES;
        end
        for (int i = 0; i < NUM_SOURCES; i++) begin
            m[i] = (i < eff);
        end
        return m;
    endfunction

    // Handshakes
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;

    // Sort key: value with sign flipped, then source, so ties go to the lower source
    assign w_new_key  = {VALUE_BITS'($unsigned(i_in.value)) ^ SIGN, i_in.source};
    assign w_in_idx   = IDX_BITS'(i_in.source);
    assign w_head_idx = IDX_BITS'(w_head_key[SRC_BITS-1:0]);
    assign w_in_ok    = (int'(i_in.source) < NUM_SOURCES) && r_pend[w_in_idx];

    // Sequencer: fill a pending slot, then emit the minimum (or the end marker) once nothing is pending
    always_comb begin
        n_state       = r_state;
        n_active      = r_active;
        n_pend        = r_pend;
        n_out_valid   = r_out_valid;
        n_min_value   = r_min_value;
        n_from_source = r_from_source;
        n_finished    = r_finished;
        w_ctl         = '0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (w_cfg_acc) begin
            n_active  = i_cfg.data;
            n_pend    = f_restart_mask(i_cfg.data);
            w_ctl.clr = 1'b1;
            n_state   = S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (w_in_ok) begin
                            n_pend[w_in_idx] = 1'b0;
                            w_ctl.ins        = !i_in.exhausted;
                        end
                        n_state = S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (|r_pend) begin
                        n_state = S_IDLE;
                    end else if (w_out_free) begin
                        n_out_valid = 1'b1;
                        if (w_head_valid) begin
                            n_min_value   = OUT_VALUE_BITS'(w_head_key[KEY_BITS-1:SRC_BITS] ^ SIGN);
                            n_from_source = w_head_key[SRC_BITS-1:0];
                            n_finished    = 1'b0;
                            n_pend[w_head_idx] = 1'b1;
                            w_ctl.pop     = 1'b1;
                        end else begin
                            // every source done: close the stream, start over
                            n_min_value   = '0;
                            n_from_source = '0;
                            n_finished    = 1'b1;
                            n_pend        = f_restart_mask(r_active);
                        end
                        n_state = S_IDLE;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= CFG_RESET;
            r_pend      <= f_restart_mask(CFG_RESET);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_min_value   <= n_min_value;
        r_from_source <= n_from_source;
        r_finished    <= n_finished;
    end

    // Sorted chain of held heads
    kwmm_chain #(
        .NUM_CELLS (NUM_SOURCES),
        .KEY_BITS  (KEY_BITS)
    ) u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_new_key    (w_new_key),
        .o_head_key   (w_head_key),
        .o_head_valid (w_head_valid)
    );

    assign o_out.valid       = r_out_valid;
    assign o_out.min_value   = r_min_value;
    assign o_out.from_source = r_from_source;
    assign o_out.finished    = r_finished;

endmodule

// ===== tb/kwmm_checker.sv =====
`timescale 1ns / 1ps
module kwmm_checker #(
    parameter int LANES = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    kwmm_in_if   i_in,
    kwmm_out_if  i_out,
    kwmm_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_outstanding
);
    import kwmm_pkg::*;

    typedef enum logic [1:0] {
        SLOT_PENDING,
        SLOT_HOLDING,
        SLOT_DONE
    } slot_e;

    typedef struct packed {
        logic signed [OUT_VALUE_BITS-1:0] min_value;
        logic [SRC_BITS-1:0]              from_source;
        logic                             finished;
    } merge_res_t;

    // Shadow copy of the merge state
    logic [CFG_BITS-1:0]              src_count;
    slot_e                            slot_st [LANES];
    logic signed [OUT_VALUE_BITS-1:0] heads [LANES];
    merge_res_t                       merged_q [$];
    int                               fails = 0;

    // 0 behaves as 1, anything above the lane count saturates
    function automatic int live_sources(logic [CFG_BITS-1:0] n);
        if (n == 0) return 1;
        if (n > LANES) return LANES;
        return int'(n);
    endfunction

    function automatic void rearm_slots();
        for (int i = 0; i < LANES; i++) begin
            slot_st[i] = (i < live_sources(src_count)) ? SLOT_PENDING : SLOT_DONE;
        end
    endfunction

    // Apply one input transaction and queue the merged output it releases, if any
    function automatic void take_head(logic [SRC_BITS-1:0] src,
                                      logic signed [OUT_VALUE_BITS-1:0] val, logic exh);
        int         best;
        bit         waiting;
        bit         held;
        merge_res_t res;
        best    = 0;
        waiting = 1'b0;
        held    = 1'b0;
        // items for a holding or done slot leave it untouched
        if (slot_st[src] == SLOT_PENDING) begin
            if (exh) begin
                slot_st[src] = SLOT_DONE;
            end else begin
                heads[src]   = val;
                slot_st[src] = SLOT_HOLDING;
            end
        end
        // lowest value wins, ties to the lowest source
        for (int i = 0; i < LANES; i++) begin
            if (slot_st[i] == SLOT_PENDING) begin
                waiting = 1'b1;
            end else if (slot_st[i] == SLOT_HOLDING) begin
                if (!held || heads[i] < heads[best]) best = i;
                held = 1'b1;
            end
        end
        if (waiting) return;
        if (held) begin
            res.min_value   = heads[best];
            res.from_source = SRC_BITS'(best);
            res.finished    = 1'b0;
            slot_st[best]   = SLOT_PENDING;
        end else begin
            // every source exhausted: end marker, then a fresh merge
            res          = '0;
            res.finished = 1'b1;
            rearm_slots();
        end
        merged_q.push_back(res);
    endfunction

    // Watch the three channels; output is checked before the new input is applied
    always @(posedge i_clk) begin
        merge_res_t want;
        if (!i_rst_n) begin
            src_count = CFG_RESET;
            rearm_slots();
            merged_q.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (merged_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%0b",
                             $time, i_out.min_value, i_out.from_source, i_out.finished);
                end else begin
                    want = merged_q.pop_front();
                    if (i_out.min_value !== want.min_value) begin
                        fails++;
                        $display("%0t: min_value expected %0d actual %0d", $time,
                                 $signed(want.min_value), $signed(i_out.min_value));
                    end
                    if (i_out.from_source !== want.from_source) begin
                        fails++;
                        $display("%0t: from_source expected %0d actual %0d", $time,
                                 want.from_source, i_out.from_source);
                    end
                    if (i_out.finished !== want.finished) begin
                        fails++;
                        $display("%0t: finished expected %0b actual %0b", $time,
                                 want.finished, i_out.finished);
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                src_count = i_cfg.data;
                rearm_slots();
            end
            if (i_in.valid && i_in.ready) begin
                take_head(i_in.source, i_in.value, i_in.exhausted);
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= merged_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import kwmm_pkg::*;

    localparam int LANES       = 8;
    localparam int FEED_TARGET = 950;
    localparam int STALL_LIMIT = 2000;

    typedef enum logic [1:0] {
        FEED_NARROW,
        FEED_WIDE,
        FEED_SCRAMBLED
    } feed_mode_e;

    typedef struct packed {
        logic signed [OUT_VALUE_BITS-1:0] value;
        logic                             exhausted;
    } head_item_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    kwmm_in_if  in_ch ();
    kwmm_out_if out_ch ();
    kwmm_cfg_if cfg_ch ();

    int         fail_count;
    int         outstanding;
    int         idle_cycles = 0;
    int         live_count  = LANES;
    int         feed_q [$];          // sources the block is waiting on
    int         fed_cnt [LANES];
    int         seq_len [LANES];
    longint     last_head [LANES];
    feed_mode_e feed_mode;
    int         merges_done = 0;
    int         fills       = 0;
    bit         calm        = 1'b0;
    bit         parked      = 1'b1;
    bit         out_take    = 1'b0;
    logic [SRC_BITS-1:0] out_src_q;
    logic                out_fin_q;
    head_item_t          opening_q [$];
    logic [CFG_BITS-1:0] sweep [7] = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd2, 4'd9, 4'd5};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    k_way_min_merge_top #(
        .NUM_SOURCES (LANES),
        .VALUE_BITS  (OUT_VALUE_BITS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    kwmm_checker #(
        .LANES (LANES)
    ) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .i_cfg         (cfg_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // New merge: pick a value style and a length per source, all live sources pending
    function automatic void start_merge();
        int pick;
        pick      = $urandom_range(0, 7);
        feed_mode = (pick == 0) ? FEED_SCRAMBLED : (pick < 4) ? FEED_NARROW : FEED_WIDE;
        feed_q.delete();
        for (int s = 0; s < LANES; s++) begin
            fed_cnt[s] = 0;
            seq_len[s] = $urandom_range(0, 7);
            if (feed_mode == FEED_NARROW) last_head[s] = longint'($urandom_range(0, 16)) - 8;
            else last_head[s] = longint'($signed($urandom));
            if (s < live_count) feed_q.push_back(s);
        end
    endfunction

    // Next element of a source: ascending per source, except in scrambled merges
    function automatic head_item_t next_head(int s);
        head_item_t item;
        longint     span;
        item.exhausted = (fed_cnt[s] >= seq_len[s]) ||
                         (feed_mode == FEED_SCRAMBLED && $urandom_range(0, 5) == 0);
        item.value     = $urandom;
        if (!item.exhausted && feed_mode != FEED_SCRAMBLED) begin
            span = 64'sd2147483647 - last_head[s];
            if (feed_mode == FEED_NARROW) last_head[s] += $urandom_range(0, 3);
            else if ($urandom_range(0, 3) != 0)
                last_head[s] += longint'($urandom) % (span / 4 + 1);
            if (last_head[s] > 64'sd2147483647) last_head[s] = 64'sd2147483647;
            item.value = last_head[s][31:0];
        end
        fed_cnt[s]++;
        return item;
    endfunction

    task automatic park();
        if (!parked) begin
            in_ch.valid <= 1'b0;
            parked = 1'b1;
        end
    endtask

    // One input transaction after a random gap; returns at the accepting edge
    task automatic drive_item(int src, head_item_t item);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.source    <= SRC_BITS'(src);
        in_ch.value     <= item.value;
        in_ch.exhausted <= item.exhausted;
        do @(posedge i_clk); while (!in_ch.ready);
        parked = 1'b0;
    endtask

    // Noise: an item for a source that is holding or done, which must be ignored
    task automatic poke_idle_slot();
        int         cand [$];
        bit         taken;
        head_item_t item;
        for (int s = 0; s < LANES; s++) begin
            taken = 1'b0;
            foreach (feed_q[k]) if (feed_q[k] == s) taken = 1'b1;
            if (!taken) cand.push_back(s);
        end
        if (cand.size() == 0) return;
        item.value     = $urandom;
        item.exhausted = 1'($urandom_range(0, 1));
        drive_item(cand[$urandom_range(0, cand.size() - 1)], item);
    endtask

    task automatic feed_next();
        int         idx;
        int         src;
        head_item_t item;
        if ($urandom_range(0, 5) == 0) poke_idle_slot();
        idx = (opening_q.size() != 0) ? 0 : $urandom_range(0, feed_q.size() - 1);
        src = feed_q[idx];
        feed_q.delete(idx);
        item = next_head(src);
        if (opening_q.size() != 0) item = opening_q.pop_front();
        drive_item(src, item);
        fills++;
    endtask

    // Count write, only once nothing is outstanding and the last item has settled
    task automatic set_live_count(logic [CFG_BITS-1:0] n);
        park();
        while (feed_q.size() == 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= n;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        live_count = (n == 0) ? 1 : (n > LANES) ? LANES : int'(n);
        start_merge();
    endtask

    // Output transactions tell the feeder which source to supply next
    always @(posedge i_clk) begin
        out_take  <= i_rst_n && out_ch.valid && out_ch.ready;
        out_src_q <= out_ch.from_source;
        out_fin_q <= out_ch.finished;
    end

    always @(negedge i_clk) begin
        if (out_take) begin
            if (out_fin_q) begin
                start_merge();
                merges_done++;
            end else begin
                feed_q.push_back(int'(out_src_q));
            end
        end
    end

    // Result side back-pressure
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        int phase;
        int goal;
        int cut;
        int base;
        int phase_fills;
        bit partial;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.source    = '0;
        in_ch.value     = '0;
        in_ch.exhausted = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;

        // opening merge: value extremes, ties across sources, exhausted with junk value
        opening_q = '{
            head_item_t'{32'sh80000000, 1'b0}, head_item_t'{32'sh7FFFFFFF, 1'b0},
            head_item_t'{32'sd5, 1'b0},        head_item_t'{32'sd5, 1'b0},
            head_item_t'{-32'sd1, 1'b0},       head_item_t'{32'sd0, 1'b0},
            head_item_t'{32'shFFFFFFFF, 1'b1}, head_item_t'{32'sd5, 1'b0},
            head_item_t'{32'sh80000000, 1'b0}, head_item_t'{32'sd0, 1'b1},
            head_item_t'{32'sh7FFFFFFF, 1'b0}, head_item_t'{32'sd5, 1'b0},
            head_item_t'{32'sh7FFFFFFF, 1'b0}, head_item_t'{32'sh55555555, 1'b0},
            head_item_t'{32'shAAAAAAAA, 1'b0}, head_item_t'{32'sd0, 1'b1},
            head_item_t'{32'shFFFFFFFF, 1'b1}, head_item_t'{32'sh7FFFFFFF, 1'b0},
            head_item_t'{32'sd1, 1'b1},        head_item_t'{32'sh7FFFFFFF, 1'b0}
        };
        start_merge();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        phase = 0;
        while (fills < FEED_TARGET) begin
            if (phase != 0)
                set_live_count(phase <= 7 ? sweep[phase - 1] : CFG_BITS'($urandom_range(0, 15)));
            calm        = ($urandom_range(0, 4) == 0);
            goal        = (phase == 0) ? 1 : $urandom_range(1, 3);
            partial     = (phase != 0) && ($urandom_range(0, 3) == 0);
            cut         = $urandom_range(1, 12);
            base        = merges_done;
            phase_fills = 0;
            // a partial phase is cut short and restarted by the next count write
            while (merges_done - base < goal &&
                   !(partial && phase_fills >= cut && feed_q.size() != 0)) begin
                if (feed_q.size() == 0) begin
                    park();
                    @(posedge i_clk);
                end else begin
                    feed_next();
                    phase_fills++;
                end
            end
            phase++;
        end

        // drain
        park();
        while (outstanding != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
